>>> sv/iq_unpack_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_unpack_pkg
// Shared types, codes and helper functions for the packed I/Q unpacker.
// ----------------------------------------------------------------------------
package iq_unpack_pkg;

  // Default channel limit for the top-level parameter
  localparam int MaxChannels = 4;

  // Configuration port geometry
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 3;

  // Register indexes
  localparam logic [CfgIndexW-1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_IQ_SWAP       = 2'd2;

  // Wire formats
  typedef enum logic [1:0] {
    FMT_BYTE    = 2'd0,
    FMT_NIBBLE  = 2'd1,
    FMT_TWO_BIT = 2'd2,
    FMT_WORD    = 2'd3
  } fmt_t;

  typedef struct packed {
    fmt_t       sample_format;
    logic [2:0] channel_count;
    logic       iq_swap;
  } cfg_t;

  // One decoded byte: a single sample, or two samples replicated to all channels
  typedef struct packed {
    logic        has_result;
    logic        two_bit;
    logic [15:0] i0;
    logic [15:0] q0;
    logic [15:0] i1;
    logic [15:0] q1;
    logic [1:0]  ch;
    logic [1:0]  last_ch;
  } sample_desc_t;

  // Signed 4-bit code s -> odd level 2s+1
  function automatic logic [15:0] odd_level4(input logic [3:0] nib);
    return {{11{nib[3]}}, nib, 1'b1};
  endfunction

  // Signed 2-bit code s -> odd level 2s+1
  function automatic logic [15:0] odd_level2(input logic [1:0] f);
    return {{13{f[1]}}, f, 1'b1};
  endfunction

endpackage

>>> sv/iq_unpack_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_unpack_byte_if
// Valid/ready channel carrying payload bytes into the unpacker.
// ----------------------------------------------------------------------------
interface iq_unpack_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       packet_start;

  modport source(output valid, output payload_byte, output packet_start, input ready);
  modport sink(input valid, input payload_byte, input packet_start, output ready);
endinterface

>>> sv/iq_unpack_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_unpack_sample_if
// Valid/ready channel carrying complex samples out of the unpacker.
// ----------------------------------------------------------------------------
interface iq_unpack_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_i;
  logic [15:0] out_q;
  logic [1:0]  channel;
  logic        last;

  modport source(output valid, output out_i, output out_q, output channel, output last,
                 input ready);
  modport sink(input valid, input out_i, input out_q, input channel, input last,
               output ready);
endinterface

>>> sv/iq_unpack_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_unpack_decode
// Holds byte phase, partial bytes and channel index; decodes one byte per
// transaction into a sample descriptor.
// ----------------------------------------------------------------------------
module iq_unpack_decode
  import iq_unpack_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannels
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         accept,
  input  logic [7:0]   payload_byte,
  input  logic         packet_start,
  output sample_desc_t desc
);

  logic [1:0]  byte_phase, byte_phase_next;
  logic [23:0] held_bytes, held_bytes_next;
  logic [1:0]  channel_index, channel_index_next;

  logic [1:0]  ph;
  logic [23:0] hb;
  logic [1:0]  ci;
  logic [2:0]  nch;
  logic [1:0]  chn;
  logic [1:0]  ci_adv;
  logic [15:0] wa, wc;

  // Packet start clears, channel count clamp, channel pick
  always_comb begin
    ph  = packet_start ? 2'd0  : byte_phase;
    hb  = packet_start ? 24'd0 : held_bytes;
    ci  = packet_start ? 2'd0  : channel_index;
    nch = cfg.channel_count;
    if (nch == 3'd0) nch = 3'd1;
    if (nch > 3'(MAX_CHANNELS)) nch = 3'(MAX_CHANNELS);
    chn    = ({1'b0, ci} >= nch) ? 2'd0 : ci;
    ci_adv = ({1'b0, chn} + 3'd1 >= nch) ? 2'd0 : chn + 2'd1;
  end

  // Format decode
  always_comb begin
    desc               = '0;
    desc.ch            = chn;
    desc.last_ch       = 2'(nch - 3'd1);
    byte_phase_next    = 2'd0;
    held_bytes_next    = 24'd0;
    channel_index_next = ci;
    wa                 = '0;
    wc                 = '0;
    unique case (cfg.sample_format)
      FMT_BYTE: begin
        if (ph == 2'd0) begin
          held_bytes_next = {hb[15:0], payload_byte};
          byte_phase_next = 2'd1;
        end else begin
          wa = {{8{hb[7]}}, hb[7:0]};
          wc = {{8{payload_byte[7]}}, payload_byte};
          desc.has_result    = 1'b1;
          desc.i0            = cfg.iq_swap ? wa : wc;
          desc.q0            = cfg.iq_swap ? wc : wa;
          channel_index_next = ci_adv;
        end
      end
      FMT_WORD: begin
        if (ph != 2'd3) begin
          held_bytes_next = {hb[15:0], payload_byte};
          byte_phase_next = ph + 2'd1;
        end else begin
          wa = {hb[15:8], hb[23:16]};
          wc = {payload_byte, hb[7:0]};
          desc.has_result    = 1'b1;
          desc.i0            = cfg.iq_swap ? wa : wc;
          desc.q0            = cfg.iq_swap ? wc : wa;
          channel_index_next = ci_adv;
        end
      end
      FMT_NIBBLE: begin
        // nibble format: swap sense is inverted
        wa = odd_level4(payload_byte[3:0]);
        wc = odd_level4(payload_byte[7:4]);
        desc.has_result    = 1'b1;
        desc.i0            = cfg.iq_swap ? wc : wa;
        desc.q0            = cfg.iq_swap ? wa : wc;
        channel_index_next = ci_adv;
      end
      FMT_TWO_BIT: begin
        // two samples per byte, sent to every channel; index untouched
        desc.has_result = 1'b1;
        desc.two_bit    = 1'b1;
        desc.i0 = cfg.iq_swap ? odd_level2(payload_byte[5:4]) : odd_level2(payload_byte[7:6]);
        desc.q0 = cfg.iq_swap ? odd_level2(payload_byte[7:6]) : odd_level2(payload_byte[5:4]);
        desc.i1 = cfg.iq_swap ? odd_level2(payload_byte[1:0]) : odd_level2(payload_byte[3:2]);
        desc.q1 = cfg.iq_swap ? odd_level2(payload_byte[3:2]) : odd_level2(payload_byte[1:0]);
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= 2'd0;
      held_bytes    <= 24'd0;
      channel_index <= 2'd0;
    end else if (accept) begin
      byte_phase    <= byte_phase_next;
      held_bytes    <= held_bytes_next;
      channel_index <= channel_index_next;
    end
  end

endmodule

>>> sv/packed_iq_sample_unpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_iq_sample_unpacker
// Unpacks packed I/Q payload bytes into complex samples for 1..4 channels.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   : valid/ready sink, one payload byte per transaction; packet_start
//             marks the first byte of a packet.
//   samples : valid/ready source, one complex sample per transaction with its
//             channel; last flags the final sample caused by a byte.
//   cfg     : write port (cfg_write, cfg_index, cfg_data); write only while
//             no byte is in flight.
// Registered output: a sample appears the cycle after its final byte is taken.
// Throughput: while samples.ready is high, one byte per cycle in byte, 16-bit
//   and nibble formats. In the two-bit format a byte expands to 2 * channels
//   samples, likewise emitted one per cycle from the output register.
// Bytes that only complete part of a pair produce no sample.
// Stall: the output register holds its sample while samples.ready is low;
//   bytes.ready drops until the last pending sample is taken.
// Reset: config returns to byte format, one channel, no swap; byte phase,
//   partial bytes, channel index, output valid flag and emit sequencer clear.
// ----------------------------------------------------------------------------
module packed_iq_sample_unpacker
  import iq_unpack_pkg::*;
#(
  parameter int MAX_CHANNELS = MaxChannels
) (
  input  logic                 clk,
  input  logic                 rst,
  iq_unpack_byte_if.sink       bytes,
  iq_unpack_sample_if.source   samples,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t         cfg;
  sample_desc_t desc;
  sample_desc_t pend;
  logic         pend_valid;
  logic         emit_sub;
  logic [1:0]   emit_ch;
  logic         emit_last;
  logic         accept;
  logic         out_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_format <= FMT_BYTE;
      cfg.channel_count <= 3'd1;
      cfg.iq_swap       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SAMPLE_FORMAT: cfg.sample_format <= fmt_t'(cfg_data[1:0]);
        REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data;
        REG_IQ_SWAP:       cfg.iq_swap       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  iq_unpack_decode #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .payload_byte (bytes.payload_byte),
    .packet_start (bytes.packet_start),
    .desc         (desc)
  );

  // Handshakes
  assign emit_last     = !pend.two_bit || (emit_sub && (emit_ch == pend.last_ch));
  assign out_take      = samples.valid && samples.ready;
  assign bytes.ready   = !pend_valid || (samples.ready && emit_last);
  assign accept        = bytes.valid && bytes.ready;

  // Output register control and emit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      emit_sub   <= 1'b0;
      emit_ch    <= 2'd0;
    end else if (accept && desc.has_result) begin
      pend_valid <= 1'b1;
      emit_sub   <= 1'b0;
      emit_ch    <= 2'd0;
    end else if (out_take && emit_last) begin
      pend_valid <= 1'b0;
    end else if (out_take) begin
      emit_sub <= ~emit_sub;
      if (emit_sub) begin
        emit_ch <= emit_ch + 2'd1;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (accept && desc.has_result) begin
      pend <= desc;
    end
  end

  assign samples.valid   = pend_valid;
  assign samples.out_i   = (pend.two_bit && emit_sub) ? pend.i1 : pend.i0;
  assign samples.out_q   = (pend.two_bit && emit_sub) ? pend.q1 : pend.q0;
  assign samples.channel = pend.two_bit ? emit_ch : pend.ch;
  assign samples.last    = emit_last;

  // A byte is only taken over a pending sample when that sample leaves now
  a_accept_frees: assert property (@(posedge clk) disable iff (rst)
    (accept && pend_valid) |-> (samples.ready && samples.last))
    else $error("byte accepted while output register still busy");

  // Last sample taken with no new result behind it empties the register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_take && samples.last && !(accept && desc.has_result)) |=> !samples.valid)
    else $error("output register did not drain after last sample");

  // Replication never runs past the last active channel
  a_ch_bound: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && pend.two_bit) |-> (emit_ch <= pend.last_ch))
    else $error("two-bit replication channel out of range");

  // Single-sample formats always flag last
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend.two_bit) |-> samples.last)
    else $error("single sample missing last flag");

  // Mid-sequence take advances the sequencer to the second sample or next channel
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (out_take && !samples.last) |=> (samples.valid && (emit_sub != $past(emit_sub))))
    else $error("replication sequencer failed to advance");

endmodule

>>> test/tb_packed_iq_sample_unpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_iq_sample_unpacker
// Self-checking bench for the packed I/Q unpacker. Payload bytes are pushed
// through the byte channel under a series of format, channel count and swap
// settings. Every accepted byte runs through a local model of the unpacker
// and the samples it should produce are queued. Each sample leaving the block
// is checked against the head of that queue. A short directed table comes
// first, followed by randomized packets. Both handshakes see random stalls.
// ----------------------------------------------------------------------------
module tb_packed_iq_sample_unpacker;
  import iq_unpack_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomBytes = 124;
  localparam int QuietFrom   = 100;
  localparam int NumRows     = 26;

  // One expected output sample
  typedef struct packed {
    logic [15:0] i;
    logic [15:0] q;
    logic [1:0]  ch;
    logic        last;
  } sample_t;

  // One row of the directed table
  typedef struct packed {
    fmt_t        fmt;
    logic [2:0]  chans;
    logic        swap;
    logic [7:0]  data;
    logic        start;
    logic        known;
    logic [15:0] ei;
    logic [15:0] eq;
    logic [1:0]  ech;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  iq_unpack_byte_if   bytes_ch ();
  iq_unpack_sample_if samples_ch ();

  packed_iq_sample_unpacker i_dut (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes_ch),
    .samples   (samples_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register mirror
  fmt_t       cfg_fmt;
  logic [2:0] cfg_chans;
  logic       cfg_swap;

  // Unpacker state mirror
  logic [1:0]  pair_phase;
  logic [23:0] held_bytes;
  logic [1:0]  next_chan;

  sample_t expected_samples[$];
  int      mismatches;
  int      cycle_count;
  bit      no_idle;

  // Directed table; expected sample typed in only for the obvious rows
  stim_row_t directed_rows [NumRows] = '{
    // byte pairs: extremes, packet start mid-pair
    '{FMT_BYTE,    3'd1, 1'b0, 8'h80, 1'b1, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_BYTE,    3'd1, 1'b0, 8'h7F, 1'b0, 1'b1, 16'h007F, 16'hFF80, 2'd0},
    '{FMT_BYTE,    3'd1, 1'b0, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_BYTE,    3'd1, 1'b0, 8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_BYTE,    3'd1, 1'b0, 8'h01, 1'b0, 1'b1, 16'h0001, 16'h0000, 2'd0},
    // 16-bit pairs, swapped, four channels
    '{FMT_WORD,    3'd4, 1'b1, 8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd4, 1'b1, 8'h80, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd4, 1'b1, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd4, 1'b1, 8'h7F, 1'b0, 1'b1, 16'h8000, 16'h7FFF, 2'd0},
    '{FMT_WORD,    3'd4, 1'b1, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd4, 1'b1, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd4, 1'b1, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd4, 1'b1, 8'h00, 1'b0, 1'b1, 16'hFFFF, 16'h0000, 2'd1},
    // nibbles, count of zero, channel index left beyond count
    '{FMT_NIBBLE,  3'd0, 1'b0, 8'h0F, 1'b0, 1'b1, 16'hFFFF, 16'h0001, 2'd0},
    '{FMT_NIBBLE,  3'd0, 1'b0, 8'h78, 1'b0, 1'b1, 16'hFFF1, 16'h000F, 2'd0},
    // nibbles, count above the limit, swapped
    '{FMT_NIBBLE,  3'd7, 1'b1, 8'h80, 1'b0, 1'b1, 16'hFFF1, 16'h0001, 2'd0},
    // two-bit, replicated to every channel
    '{FMT_TWO_BIT, 3'd4, 1'b0, 8'h1B, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_TWO_BIT, 3'd4, 1'b1, 8'hE4, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_TWO_BIT, 3'd1, 1'b0, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    // byte phase carried into 16-bit pairs
    '{FMT_BYTE,    3'd2, 1'b0, 8'h12, 1'b1, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd2, 1'b0, 8'h34, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd2, 1'b0, 8'h56, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd2, 1'b0, 8'h78, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    // 16-bit phase cut short by a switch to byte pairs
    '{FMT_WORD,    3'd2, 1'b0, 8'hAA, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_WORD,    3'd2, 1'b0, 8'hBB, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0},
    '{FMT_BYTE,    3'd2, 1'b0, 8'hCC, 1'b0, 1'b0, 16'h0000, 16'h0000, 2'd0}
  };

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("packed_iq_sample_unpacker verification failed");
      $finish;
    end
  end

  // Signed code of the given width -> odd level 2s+1
  function automatic int odd_level(input int code, input int bits);
    int s;
    s = (code >= (1 << (bits - 1))) ? code - (1 << bits) : code;
    return 2 * s + 1;
  endfunction

  function automatic int active_chans();
    if (cfg_chans == 3'd0) return 1;
    if (int'(cfg_chans) > MaxChannels) return MaxChannels;
    return int'(cfg_chans);
  endfunction

  // Channel for the next single sample; advances and wraps
  function automatic logic [1:0] take_chan();
    int         nch;
    logic [1:0] ch;
    nch = active_chans();
    ch = (int'(next_chan) >= nch) ? 2'd0 : next_chan;
    next_chan = (int'(ch) + 1 >= nch) ? 2'd0 : 2'(ch + 2'd1);
    return ch;
  endfunction

  function automatic sample_t mk_sample(input int iv, input int qv, input logic [1:0] ch);
    sample_t s;
    s.i = 16'(iv);
    s.q = 16'(qv);
    s.ch = ch;
    s.last = 1'b0;
    return s;
  endfunction

  // Samples caused by one payload byte, state updated
  task automatic unpack_byte(input logic [7:0] b, input logic start,
                             output sample_t res [8], output int n);
    int         a;
    int         c;
    int         lv [4];
    logic [1:0] ch;
    n = 0;
    if (start) begin
      pair_phase = 2'd0;
      held_bytes = 24'd0;
      next_chan = 2'd0;
    end
    case (cfg_fmt)
      FMT_BYTE: begin
        if (pair_phase == 2'd0) begin
          held_bytes = {held_bytes[15:0], b};
          pair_phase = 2'd1;
        end else begin
          a = int'($signed(held_bytes[7:0]));
          c = int'($signed(b));
          pair_phase = 2'd0;
          held_bytes = 24'd0;
          ch = take_chan();
          res[0] = cfg_swap ? mk_sample(a, c, ch) : mk_sample(c, a, ch);
          n = 1;
        end
      end
      FMT_WORD: begin
        if (pair_phase != 2'd3) begin
          held_bytes = {held_bytes[15:0], b};
          pair_phase = pair_phase + 2'd1;
        end else begin
          a = int'($signed({held_bytes[15:8], held_bytes[23:16]}));
          c = int'($signed({b, held_bytes[7:0]}));
          pair_phase = 2'd0;
          held_bytes = 24'd0;
          ch = take_chan();
          res[0] = cfg_swap ? mk_sample(a, c, ch) : mk_sample(c, a, ch);
          n = 1;
        end
      end
      FMT_NIBBLE: begin
        pair_phase = 2'd0;
        held_bytes = 24'd0;
        a = odd_level(int'(b[3:0]), 4);
        c = odd_level(int'(b[7:4]), 4);
        ch = take_chan();
        // nibble swap sense is inverted
        res[0] = cfg_swap ? mk_sample(c, a, ch) : mk_sample(a, c, ch);
        n = 1;
      end
      default: begin
        pair_phase = 2'd0;
        held_bytes = 24'd0;
        lv[0] = odd_level(int'(b[7:6]), 2);
        lv[1] = odd_level(int'(b[5:4]), 2);
        lv[2] = odd_level(int'(b[3:2]), 2);
        lv[3] = odd_level(int'(b[1:0]), 2);
        // both samples to every channel, channel index untouched
        for (int k = 0; k < active_chans(); k++) begin
          for (int s = 0; s < 2; s++) begin
            res[n] = cfg_swap ? mk_sample(lv[2*s+1], lv[2*s], 2'(k))
                              : mk_sample(lv[2*s], lv[2*s+1], 2'(k));
            n++;
          end
        end
      end
    endcase
    if (n > 0) res[n-1].last = 1'b1;
  endtask

  // Drive one byte transaction and queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic start,
                           input logic known, input sample_t typed);
    sample_t res [8];
    int      n;
    bytes_ch.valid = 1'b1;
    bytes_ch.payload_byte = b;
    bytes_ch.packet_start = start;
    do @(posedge clk); while (!bytes_ch.ready);
    unpack_byte(b, start, res, n);
    if (known) expected_samples.push_back(typed);
    else for (int k = 0; k < n; k++) expected_samples.push_back(res[k]);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      bytes_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Block idle: wait until nothing is queued, then wait out any byte in flight
  task automatic drain();
    bytes_ch.valid = 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_config(input fmt_t f, input logic [2:0] chans, input logic swap);
    cfg_write = 1'b1;
    cfg_index = REG_SAMPLE_FORMAT;
    cfg_data = CfgDataW'(f);
    @(negedge clk);
    cfg_index = REG_CHANNEL_COUNT;
    cfg_data = chans;
    @(negedge clk);
    cfg_index = REG_IQ_SWAP;
    cfg_data = CfgDataW'(swap);
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_fmt = f;
    cfg_chans = chans;
    cfg_swap = swap;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Sample checker
  always @(posedge clk) begin
    sample_t want;
    if (!rst && samples_ch.valid && samples_ch.ready) begin
      if (expected_samples.size() == 0) begin
        $error("sample with none expected: i=%h q=%h channel=%0d last=%0b",
               samples_ch.out_i, samples_ch.out_q, samples_ch.channel, samples_ch.last);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (samples_ch.out_i !== want.i) begin
          $error("out_i: expected %h, actual %h", want.i, samples_ch.out_i);
          mismatches++;
        end
        if (samples_ch.out_q !== want.q) begin
          $error("out_q: expected %h, actual %h", want.q, samples_ch.out_q);
          mismatches++;
        end
        if (samples_ch.channel !== want.ch) begin
          $error("channel: expected %0d, actual %0d", want.ch, samples_ch.channel);
          mismatches++;
        end
        if (samples_ch.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, samples_ch.last);
          mismatches++;
        end
      end
    end
  end

  // Sample sink with random stall bursts
  initial begin
    int stall;
    stall = 0;
    samples_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        samples_ch.ready = 1'b0;
        stall--;
      end else if (!no_idle && $urandom_range(0, 6) == 0) begin
        samples_ch.ready = 1'b0;
        stall = $urandom_range(0, 3);
      end else begin
        samples_ch.ready = 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    stim_row_t row;
    sample_t   typed;
    fmt_t      f;
    logic [2:0] chans;
    logic      swap;
    int        sent;
    int        phase_no;
    int        unit;
    int        len;
    bit        broken;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    bytes_ch.valid = 1'b0;
    bytes_ch.payload_byte = 8'h00;
    bytes_ch.packet_start = 1'b0;
    cfg_fmt = FMT_BYTE;
    cfg_chans = 3'd1;
    cfg_swap = 1'b0;
    pair_phase = 2'd0;
    held_bytes = 24'd0;
    next_chan = 2'd0;
    mismatches = 0;
    cycle_count = 0;
    no_idle = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed table
    for (int r = 0; r < NumRows; r++) begin
      row = directed_rows[r];
      if (r == 0 || row.fmt != cfg_fmt || row.chans != cfg_chans || row.swap != cfg_swap)
      begin
        drain();
        write_config(row.fmt, row.chans, row.swap);
      end
      typed = '{row.ei, row.eq, row.ech, 1'b1};
      send_byte(row.data, row.start, row.known, typed);
    end

    // Random packets under a series of settings
    sent = 0;
    phase_no = 0;
    while (sent < RandomBytes) begin
      case (phase_no)
        0: begin f = FMT_WORD;    chans = 3'd4; swap = 1'b1; end
        1: begin f = FMT_TWO_BIT; chans = 3'd4; swap = 1'b0; end
        2: begin f = FMT_BYTE;    chans = 3'd1; swap = 1'b0; end
        3: begin f = FMT_NIBBLE;  chans = 3'd3; swap = 1'b1; end
        default: begin
          f = fmt_t'($urandom_range(0, 3));
          chans = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(1, 4));
          swap = 1'($urandom_range(0, 1));
        end
      endcase
      drain();
      write_config(f, chans, swap);
      unit = (f == FMT_BYTE) ? 2 : (f == FMT_WORD) ? 4 : 1;
      repeat ($urandom_range(1, 4)) begin
        broken = ($urandom_range(0, 5) == 0);
        len = broken ? $urandom_range(1, 9) : unit * $urandom_range(1, 6);
        for (int k = 0; k < len && sent < RandomBytes; k++) begin
          if (sent >= QuietFrom) no_idle = 1'b1;
          if (broken)
            send_byte(pick_byte(), (k == 0) ? 1'($urandom_range(0, 1))
                                            : ($urandom_range(0, 7) == 0), 1'b0, '0);
          else
            send_byte(pick_byte(), k == 0, 1'b0, '0);
          sent++;
        end
      end
      phase_no++;
    end

    // Wind down
    bytes_ch.valid = 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("packed_iq_sample_unpacker verification clean");
    end else begin
      $display("packed_iq_sample_unpacker verification failed");
    end
    $finish;
  end

endmodule
